// ----- rtl/core/lcfs_pkg.sv -----
// Shared types, constants and helpers for the line column/field selector.
`default_nettype none

package lcfs_pkg;

    localparam int LINE_CAP    = 63;
    localparam int IDX_W       = 6;
    localparam int STORE_DEPTH = 2 * (1 << IDX_W);
    localparam int ADDR_W      = IDX_W + 1;
    localparam int MAP_W       = 256;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [7:0] CHAR_NL  = 8'h0A;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_TAB = 8'h09;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CMODE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM = 3'd5;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } t_in_req;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       line_end;
    } t_out_req;

    typedef struct packed {
        logic [MAP_W-1:0] sel_map;
        logic             char_mode;
        logic [7:0]       delimiter;
    } t_cfg;

    typedef struct packed {
        logic             bank;
        logic [IDX_W-1:0] len;
        logic             found;
    } t_job;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DATA,
        S_NL
    } t_back_state;

    function automatic logic f_selected(logic [MAP_W-1:0] map, logic [7:0] pos);
        return map[pos];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/lcfs_ram.sv -----
// Generic simple dual-port RAM with registered read.
`default_nettype none

module lcfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/core/lcfs_front.sv -----
// Front end: accepts stream bytes, fills the line store and posts line jobs.
`default_nettype none

module lcfs_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire lcfs_pkg::t_in_req           i_in,
    input  wire logic [7:0]                  i_delimiter,
    input  wire logic                        i_job_full,
    output logic                             o_job_push,
    output lcfs_pkg::t_job                   o_job,
    output logic                             o_we,
    output logic [lcfs_pkg::ADDR_W-1:0]      o_waddr,
    output logic [7:0]                       o_wdata
);

    logic                         r_bank;
    logic                         n_bank;
    logic [lcfs_pkg::IDX_W-1:0]   r_len;
    logic [lcfs_pkg::IDX_W-1:0]   n_len;
    logic                         r_found;
    logic                         n_found;
    logic                         accept;
    logic                         close;

    assign o_in_ready = !i_job_full;
    assign accept     = i_in_valid && !i_job_full;

    always_comb begin
        n_bank  = r_bank;
        n_len   = r_len;
        n_found = r_found;
        close   = 1'b0;
        o_we    = 1'b0;
        if (accept) begin
            if (i_in.end_of_input) begin
                close = (r_len != '0);
            end else if (i_in.in_byte == lcfs_pkg::CHAR_NL) begin
                close = 1'b1;
            end else if (i_in.in_byte != lcfs_pkg::CHAR_CR &&
                         r_len != lcfs_pkg::IDX_W'(lcfs_pkg::LINE_CAP)) begin
                o_we    = 1'b1;
                n_len   = r_len + 1'b1;
                n_found = r_found || (i_in.in_byte == i_delimiter);
            end
        end
        if (close) begin
            n_bank  = !r_bank;
            n_len   = '0;
            n_found = 1'b0;
        end
    end

    assign o_job_push  = close;
    assign o_job.bank  = r_bank;
    assign o_job.len   = r_len;
    assign o_job.found = r_found;
    assign o_waddr     = {r_bank, r_len};
    assign o_wdata     = i_in.in_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank  <= 1'b0;
            r_len   <= '0;
            r_found <= 1'b0;
        end else begin
            r_bank  <= n_bank;
            r_len   <= n_len;
            r_found <= n_found;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/lcfs_job_fifo.sv -----
// Two-entry queue of line jobs between the front and back ends.
`default_nettype none

module lcfs_job_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire lcfs_pkg::t_job i_job,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_empty,
    output lcfs_pkg::t_job      o_job
);

    lcfs_pkg::t_job r_entry [2];
    logic           r_wptr;
    logic           r_rptr;
    logic [1:0]     r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_job   = r_entry[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/lcfs_back.sv -----
// Back end: replays a stored line, applies the selection and drives results.
`default_nettype none

module lcfs_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire lcfs_pkg::t_cfg              i_cfg,
    input  wire logic                        i_job_empty,
    input  wire lcfs_pkg::t_job              i_job,
    output logic                             o_job_pop,
    output logic                             o_re,
    output logic [lcfs_pkg::ADDR_W-1:0]      o_raddr,
    input  wire logic [7:0]                  i_rdata,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output lcfs_pkg::t_out_req               o_out
);

    lcfs_pkg::t_back_state        r_state;
    lcfs_pkg::t_back_state        n_state;
    logic [lcfs_pkg::IDX_W-1:0]   r_idx;
    logic [lcfs_pkg::IDX_W-1:0]   n_idx;
    logic [6:0]                   r_field;
    logic [6:0]                   n_field;
    logic                         r_first;
    logic                         n_first;
    logic                         r_out_valid;
    logic                         n_out_valid;
    lcfs_pkg::t_out_req           r_out;
    lcfs_pkg::t_out_req           n_out;
    logic                         out_free;
    logic                         emit;
    logic                         advance;
    logic                         last;
    logic [7:0]                   pos;
    logic [7:0]                   field_cur;
    logic [7:0]                   field_nxt;
    logic                         is_delim;

    assign out_free  = !r_out_valid || i_out_ready;
    assign pos       = {2'b00, r_idx} + 8'd1;
    assign field_cur = {1'b0, r_field};
    assign field_nxt = {1'b0, r_field} + 8'd1;
    assign is_delim  = (i_rdata == i_cfg.delimiter);
    assign last      = (r_idx + 1'b1 == i_job.len);

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_field     = r_field;
        n_first     = r_first;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_job_pop   = 1'b0;
        o_re        = 1'b0;
        o_raddr     = {i_job.bank, lcfs_pkg::IDX_W'(0)};
        emit        = 1'b0;
        advance     = 1'b0;

        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            lcfs_pkg::S_IDLE: begin
                if (!i_job_empty) begin
                    n_idx   = '0;
                    n_field = 7'd1;
                    n_first = !lcfs_pkg::f_selected(i_cfg.sel_map, 8'd1);
                    if (i_job.len == '0) begin
                        n_state = lcfs_pkg::S_NL;
                    end else begin
                        o_re    = 1'b1;
                        n_state = lcfs_pkg::S_DATA;
                    end
                end
            end
            lcfs_pkg::S_DATA: begin
                if (i_cfg.char_mode) begin
                    emit = lcfs_pkg::f_selected(i_cfg.sel_map, pos);
                end else if (!i_job.found) begin
                    emit = 1'b1;
                end else if (is_delim) begin
                    emit = lcfs_pkg::f_selected(i_cfg.sel_map, field_nxt) && !r_first;
                end else begin
                    emit = lcfs_pkg::f_selected(i_cfg.sel_map, field_cur);
                end
                advance = !emit || out_free;
                if (advance) begin
                    if (emit) begin
                        n_out_valid       = 1'b1;
                        n_out.out_byte    = i_rdata;
                        n_out.line_end    = 1'b0;
                    end
                    if (!i_cfg.char_mode && i_job.found && is_delim) begin
                        n_field = field_nxt[6:0];
                        if (lcfs_pkg::f_selected(i_cfg.sel_map, field_nxt)) begin
                            n_first = 1'b0;
                        end
                    end
                    if (last) begin
                        n_state = lcfs_pkg::S_NL;
                    end else begin
                        o_re    = 1'b1;
                        o_raddr = {i_job.bank, r_idx + 1'b1};
                        n_idx   = r_idx + 1'b1;
                    end
                end
            end
            lcfs_pkg::S_NL: begin
                if (out_free) begin
                    n_out_valid    = 1'b1;
                    n_out.out_byte = lcfs_pkg::CHAR_NL;
                    n_out.line_end = 1'b1;
                    o_job_pop      = 1'b1;
                    n_state        = lcfs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lcfs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lcfs_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_field <= n_field;
        r_first <= n_first;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// ----- rtl/core/line_column_field_selector.sv -----
// Top level of the streaming column/field selector.
//
// Input channel (i_in_valid / o_in_ready, payload i_in) carries one text
// byte per request, or an end-of-input marker. Output channel
// (o_out_valid / i_out_ready, payload o_out) carries the cut bytes, each
// line closed by a newline request with line_end set.
// Configuration: write i_cfg_data to register i_cfg_idx while i_cfg_we is
// high: selection maps 0..3, character mode, delimiter. Write only when idle.
// The front end takes one byte per cycle, while the job queue has room, into
// one of two line banks of the store. A newline, or end of input after a
// non-empty line, queues the line; the back end replays it from the store at
// one stored byte per cycle unless the receiver stalls, bound by the single
// read port. With the back end idle and the receiver ready, a closed line goes
// through the job queue, the store's registered read and the output register,
// and its closing newline follows its last byte. While both banks hold lines
// that are not yet fully replayed, o_in_ready stays low.
// Reset clears the line length, the job queue and the output valid flag and
// loads the default registers (tab delimiter, field mode, empty map).
// A stalled receiver holds the output register and freezes the replay at the
// next byte to emit; the front end keeps filling its free bank meanwhile.
`default_nettype none

module line_column_field_selector (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire lcfs_pkg::t_in_req                   i_in,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output lcfs_pkg::t_out_req                       o_out,
    input  wire logic                                i_cfg_we,
    input  wire logic [lcfs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [lcfs_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    lcfs_pkg::t_cfg                  r_cfg;
    lcfs_pkg::t_job                  push_job;
    lcfs_pkg::t_job                  head_job;
    logic                            job_push;
    logic                            job_pop;
    logic                            job_full;
    logic                            job_empty;
    logic                            we;
    logic [lcfs_pkg::ADDR_W-1:0]     waddr;
    logic [7:0]                      wdata;
    logic                            re;
    logic [lcfs_pkg::ADDR_W-1:0]     raddr;
    logic [7:0]                      rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sel_map   <= '0;
            r_cfg.char_mode <= 1'b0;
            r_cfg.delimiter <= lcfs_pkg::CHAR_TAB;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lcfs_pkg::CFG_MAP0:  r_cfg.sel_map[63:0]    <= i_cfg_data;
                lcfs_pkg::CFG_MAP1:  r_cfg.sel_map[127:64]  <= i_cfg_data;
                lcfs_pkg::CFG_MAP2:  r_cfg.sel_map[191:128] <= i_cfg_data;
                lcfs_pkg::CFG_MAP3:  r_cfg.sel_map[255:192] <= i_cfg_data;
                lcfs_pkg::CFG_CMODE: r_cfg.char_mode        <= i_cfg_data[0];
                lcfs_pkg::CFG_DELIM: r_cfg.delimiter        <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    lcfs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .i_delimiter (r_cfg.delimiter),
        .i_job_full  (job_full),
        .o_job_push  (job_push),
        .o_job       (push_job),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata)
    );

    lcfs_ram #(
        .WIDTH (8),
        .DEPTH (lcfs_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    lcfs_job_fifo u_jobs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (push_job),
        .i_pop   (job_pop),
        .o_full  (job_full),
        .o_empty (job_empty),
        .o_job   (head_job)
    );

    lcfs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_empty (job_empty),
        .i_job       (head_job),
        .o_job_pop   (job_pop),
        .o_re        (re),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire
